// File: hdl/ugs_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and register map of the ultrasonic gate sequencer.
package ugs_pkg;

    localparam int ECHO_COUNT_BITS_DEF = 16;
    localparam int WAIT_COUNT_BITS_DEF = 24;

    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 24;
    localparam int DIST_BITS      = 11;

    localparam logic [CFG_INDEX_BITS-1:0] REG_SETTLE_TICKS    = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_TRIGGER_TICKS   = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_NEAR_CM         = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FAR_CM          = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_IDLE_WAIT_TICKS = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_EXIT_WAIT_TICKS = 3'd5;

    localparam logic [7:0]  SETTLE_TICKS_RST    = 8'd2;
    localparam logic [7:0]  TRIGGER_TICKS_RST   = 8'd10;
    localparam logic [10:0] NEAR_CM_RST         = 11'd50;
    localparam logic [10:0] FAR_CM_RST          = 11'd60;
    localparam logic [23:0] IDLE_WAIT_TICKS_RST = 24'd500000;
    localparam logic [23:0] EXIT_WAIT_TICKS_RST = 24'd2000000;

    localparam logic [DIST_BITS-1:0] DIST_MUL = 11'd1124;
    localparam logic [DIST_BITS-1:0] DIST_MAX = 11'd1124;

    typedef struct packed {
        logic [7:0]  settle_ticks;
        logic [7:0]  trigger_ticks;
        logic [10:0] near_cm;
        logic [10:0] far_cm;
        logic [23:0] idle_wait_ticks;
        logic [23:0] exit_wait_ticks;
    } ugs_cfg_t;

    typedef struct packed {
        logic                 trigger_out;
        logic                 gate_pin;
        logic                 photo_request;
        logic                 distance_valid;
        logic [DIST_BITS-1:0] distance_cm;
    } ugs_result_t;

endpackage

// File: hdl/ultrasonic_gate_sequencer.sv
`timescale 1ns / 1ps
// Top level of the ultrasonic gate sequencer: configuration registers and handshakes.
//
// Each input transaction is one 1 us tick carrying the echo level, a button event
// and the access verdict; each tick yields exactly one result transaction with the
// trigger level, gate drive, photo request and distance.
// Input channel: in_valid / in_stall. Output channel: out_valid / out_stall.
// A transaction is taken at a clock edge where valid is high and stall is low.
// The result is captured in the output register when its tick is accepted.
// Throughput: one tick per cycle while the receiver does not stall; the sequencer
// state and the output register both update in the accepting cycle.
// When the receiver stalls with a result held, in_stall rises in the same cycle
// and the held result stays unchanged until taken; the output register frees as
// the result leaves, so a new tick is taken in that same cycle.
// Configuration: cfg_write with cfg_index and cfg_data writes one register per
// cycle; indexes beyond the register list are dropped. Write only while idle.
// Reset: the sequencer starts in the settle phase, gate closed, monitor mode,
// distance 0, registers at their defaults, no result pending.
module ultrasonic_gate_sequencer #(
    parameter int ECHO_COUNT_BITS = ugs_pkg::ECHO_COUNT_BITS_DEF,
    parameter int WAIT_COUNT_BITS = ugs_pkg::WAIT_COUNT_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                echo_level,
    input  logic                                button_press,
    input  logic                                verdict_valid,
    input  logic                                verdict_granted,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                trigger_out,
    output logic                                gate_pin,
    output logic                                photo_request,
    output logic                                distance_valid,
    output logic [ugs_pkg::DIST_BITS-1:0]       distance_cm,
    input  logic                                cfg_write,
    input  logic [ugs_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [ugs_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

    ugs_pkg::ugs_cfg_t    cfg_reg;
    ugs_pkg::ugs_result_t res;
    ugs_pkg::ugs_result_t res_reg;
    logic                 out_valid_reg, out_valid_next;
    logic                 accept;

    assign in_stall = out_valid_reg & out_stall;
    assign accept   = in_valid & ~in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.settle_ticks    <= ugs_pkg::SETTLE_TICKS_RST;
            cfg_reg.trigger_ticks   <= ugs_pkg::TRIGGER_TICKS_RST;
            cfg_reg.near_cm         <= ugs_pkg::NEAR_CM_RST;
            cfg_reg.far_cm          <= ugs_pkg::FAR_CM_RST;
            cfg_reg.idle_wait_ticks <= ugs_pkg::IDLE_WAIT_TICKS_RST;
            cfg_reg.exit_wait_ticks <= ugs_pkg::EXIT_WAIT_TICKS_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                ugs_pkg::REG_SETTLE_TICKS:    cfg_reg.settle_ticks    <= cfg_data[7:0];
                ugs_pkg::REG_TRIGGER_TICKS:   cfg_reg.trigger_ticks   <= cfg_data[7:0];
                ugs_pkg::REG_NEAR_CM:         cfg_reg.near_cm         <= cfg_data[10:0];
                ugs_pkg::REG_FAR_CM:          cfg_reg.far_cm          <= cfg_data[10:0];
                ugs_pkg::REG_IDLE_WAIT_TICKS: cfg_reg.idle_wait_ticks <= cfg_data;
                ugs_pkg::REG_EXIT_WAIT_TICKS: cfg_reg.exit_wait_ticks <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    ugs_core #(
        .ECHO_COUNT_BITS (ECHO_COUNT_BITS),
        .WAIT_COUNT_BITS (WAIT_COUNT_BITS)
    ) u_core (
        .clk             (clk),
        .rst_n           (rst_n),
        .step            (accept),
        .echo_level      (echo_level),
        .button_press    (button_press),
        .verdict_valid   (verdict_valid),
        .verdict_granted (verdict_granted),
        .cfg             (cfg_reg),
        .res             (res)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg <= res;
        end
    end

    assign out_valid      = out_valid_reg;
    assign trigger_out    = res_reg.trigger_out;
    assign gate_pin       = res_reg.gate_pin;
    assign photo_request  = res_reg.photo_request;
    assign distance_valid = res_reg.distance_valid;
    assign distance_cm    = res_reg.distance_cm;

endmodule

// File: hdl/ugs_core.sv
`timescale 1ns / 1ps
// Measurement sequencer: phase logic, counters, distance conversion and gate state.
module ugs_core #(
    parameter int ECHO_COUNT_BITS = ugs_pkg::ECHO_COUNT_BITS_DEF,
    parameter int WAIT_COUNT_BITS = ugs_pkg::WAIT_COUNT_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic                echo_level,
    input  logic                button_press,
    input  logic                verdict_valid,
    input  logic                verdict_granted,
    input  ugs_pkg::ugs_cfg_t   cfg,
    output ugs_pkg::ugs_result_t res
);

    localparam logic [2:0] PH_SETTLE  = 3'd0;
    localparam logic [2:0] PH_PULSE   = 3'd1;
    localparam logic [2:0] PH_RISE    = 3'd2;
    localparam logic [2:0] PH_MEASURE = 3'd3;
    localparam logic [2:0] PH_VERDICT = 3'd4;
    localparam logic [2:0] PH_WAIT    = 3'd5;

    localparam int TGT_BITS  = (WAIT_COUNT_BITS > 24) ? WAIT_COUNT_BITS : 24;
    localparam int PROD_BITS = ECHO_COUNT_BITS + ugs_pkg::DIST_BITS;

    localparam logic [TGT_BITS-1:0] WAIT_MAX =
        TGT_BITS'({WAIT_COUNT_BITS{1'b1}});

    logic [2:0]                     phase_reg, phase_next;
    logic                           exit_watch_reg, exit_watch_next;
    logic                           gate_open_reg, gate_open_next;
    logic [WAIT_COUNT_BITS-1:0]     tick_count_reg, tick_count_next;
    logic [ECHO_COUNT_BITS-1:0]     echo_width_reg, echo_width_next;
    logic [ugs_pkg::DIST_BITS-1:0]  last_distance_reg, last_distance_next;

    logic [WAIT_COUNT_BITS:0]       tick_inc;
    logic [TGT_BITS-1:0]            target_raw;
    logic [TGT_BITS-1:0]            target;
    logic [PROD_BITS-1:0]           prod;
    logic [PROD_BITS-1:0]           dist_raw;
    logic [ugs_pkg::DIST_BITS-1:0]  dist_sat;
    logic                           gate_after;
    logic                           trig;
    logic                           photo;
    logic                           dvalid;

    assign tick_inc   = {1'b0, tick_count_reg} + {{WAIT_COUNT_BITS{1'b0}}, 1'b1};
    assign target_raw = exit_watch_reg ? TGT_BITS'(cfg.exit_wait_ticks)
                                       : TGT_BITS'(cfg.idle_wait_ticks);
    assign target     = (target_raw > WAIT_MAX) ? WAIT_MAX : target_raw;
    assign prod       = PROD_BITS'(echo_width_reg) * PROD_BITS'(ugs_pkg::DIST_MUL);
    assign dist_raw   = prod >> 16;
    assign dist_sat   = (dist_raw > PROD_BITS'(ugs_pkg::DIST_MAX)) ? ugs_pkg::DIST_MAX
                                                                   : dist_raw[10:0];

    always_comb
    begin
        phase_next         = phase_reg;
        exit_watch_next    = exit_watch_reg;
        gate_after         = gate_open_reg;
        tick_count_next    = tick_count_reg;
        echo_width_next    = echo_width_reg;
        last_distance_next = last_distance_reg;
        trig               = 1'b0;
        photo              = 1'b0;
        dvalid             = 1'b0;
        case (phase_reg)
            PH_PULSE:
            begin
                trig            = 1'b1;
                tick_count_next = tick_inc[WAIT_COUNT_BITS-1:0];
                if (tick_inc >= (WAIT_COUNT_BITS+1)'(cfg.trigger_ticks))
                begin
                    phase_next      = PH_RISE;
                    tick_count_next = '0;
                end
            end
            PH_RISE:
            begin
                if (echo_level)
                begin
                    echo_width_next = ECHO_COUNT_BITS'(1);
                    phase_next      = PH_MEASURE;
                end
            end
            PH_MEASURE:
            begin
                if (echo_level)
                begin
                    if (echo_width_reg != {ECHO_COUNT_BITS{1'b1}})
                    begin
                        echo_width_next = echo_width_reg + ECHO_COUNT_BITS'(1);
                    end
                end
                else
                begin
                    last_distance_next = dist_sat;
                    dvalid             = 1'b1;
                    tick_count_next    = '0;
                    phase_next         = PH_WAIT;
                    if (!exit_watch_reg)
                    begin
                        if (dist_sat < cfg.near_cm)
                        begin
                            photo      = 1'b1;
                            phase_next = PH_VERDICT;
                        end
                    end
                    else if (dist_sat >= cfg.far_cm)
                    begin
                        gate_after      = 1'b0;
                        exit_watch_next = 1'b0;
                    end
                end
            end
            PH_VERDICT:
            begin
                if (verdict_valid)
                begin
                    tick_count_next = '0;
                    if (verdict_granted)
                    begin
                        gate_after      = 1'b1;
                        exit_watch_next = 1'b1;
                        phase_next      = PH_SETTLE;
                    end
                    else
                    begin
                        phase_next = PH_WAIT;
                    end
                end
            end
            PH_WAIT:
            begin
                tick_count_next = tick_inc[WAIT_COUNT_BITS-1:0];
                if ((TGT_BITS+1)'(tick_inc) >= (TGT_BITS+1)'(target))
                begin
                    phase_next      = PH_SETTLE;
                    tick_count_next = '0;
                end
            end
            default:
            begin
                phase_next      = PH_SETTLE;
                tick_count_next = tick_inc[WAIT_COUNT_BITS-1:0];
                if (tick_inc >= (WAIT_COUNT_BITS+1)'(cfg.settle_ticks))
                begin
                    phase_next      = PH_PULSE;
                    tick_count_next = '0;
                end
            end
        endcase
        gate_open_next = gate_after ^ button_press;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_SETTLE;
            exit_watch_reg    <= 1'b0;
            gate_open_reg     <= 1'b0;
            tick_count_reg    <= '0;
            echo_width_reg    <= '0;
            last_distance_reg <= '0;
        end
        else if (step)
        begin
            phase_reg         <= phase_next;
            exit_watch_reg    <= exit_watch_next;
            gate_open_reg     <= gate_open_next;
            tick_count_reg    <= tick_count_next;
            echo_width_reg    <= echo_width_next;
            last_distance_reg <= last_distance_next;
        end
    end

    assign res.trigger_out    = trig;
    assign res.gate_pin       = ~gate_open_next;
    assign res.photo_request  = photo;
    assign res.distance_valid = dvalid;
    assign res.distance_cm    = last_distance_next;

endmodule
